FILE: design/qdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdt_pkg
// Shared types, constants and helpers of the quoted delimiter tokenizer.
// ----------------------------------------------------------------------------
package qdt_pkg;

	localparam int SET_SIZE = 8;
	localparam int SET_W    = SET_SIZE * 8;
	localparam int CNT_W    = 4;

	// result queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// input action codes
	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_CHARS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEPT_CHARS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEPT_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_CHARS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_COUNT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CHARS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_COUNT = 3'd7;

	typedef enum logic [1:0] {
		KIND_CHAR      = 2'd0,
		KIND_TOKEN_END = 2'd1,
		KIND_DELIM     = 2'd2,
		KIND_DONE      = 2'd3
	} kind_t;

	typedef struct packed {
		logic [SET_W-1:0] split_chars;
		logic [CNT_W-1:0] split_count;
		logic [SET_W-1:0] kept_chars;
		logic [CNT_W-1:0] kept_count;
		logic [SET_W-1:0] quote_chars;
		logic [CNT_W-1:0] quote_count;
		logic [SET_W-1:0] escape_chars;
		logic [CNT_W-1:0] escape_count;
	} cfg_t;

	// All results of one item. Slot 0: token char, slot 1: token end,
	// slot 2: delimiter token or string done. Emitted in slot order.
	typedef struct packed {
		logic [2:0] mask;
		logic [7:0] ch0;
		logic [7:0] ch2;
		logic       done;
	} bundle_t;

	// counts above SET_SIZE act as SET_SIZE: the loop never goes further
	function automatic logic in_set(logic [SET_W-1:0] bytes, logic [CNT_W-1:0] count,
			logic [7:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < SET_SIZE; i++) begin
			if ((count > CNT_W'(i)) && (bytes[8*i +: 8] == c))
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

FILE: design/qdt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdt_front
// Classifies each accepted item, keeps the quote/escape/token state and
// forms the bundle of results the item causes.
// ----------------------------------------------------------------------------
module qdt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              action,
	input  logic [7:0]        in_char,
	input  qdt_pkg::cfg_t     cfg,
	output logic              bundle_valid,
	output qdt_pkg::bundle_t  bundle
);

	logic       in_quote_q, has_chars_q, esc_pend_q;
	logic [7:0] open_quote_q;

	logic       in_quote_d, has_chars_d, esc_pend_d;
	logic [7:0] open_quote_d;

	logic is_esc, is_quote, is_split, is_kept;

	assign is_esc   = qdt_pkg::in_set(cfg.escape_chars, cfg.escape_count, in_char);
	assign is_quote = qdt_pkg::in_set(cfg.quote_chars, cfg.quote_count, in_char);
	assign is_split = qdt_pkg::in_set(cfg.split_chars, cfg.split_count, in_char);
	assign is_kept  = qdt_pkg::in_set(cfg.kept_chars, cfg.kept_count, in_char);

	always_comb begin
		logic add, zero_emit, split, kept, complete;
		add       = 1'b1;
		zero_emit = 1'b0;
		split     = 1'b0;
		kept      = 1'b0;
		complete  = 1'b0;

		in_quote_d   = in_quote_q;
		open_quote_d = open_quote_q;
		has_chars_d  = has_chars_q;
		esc_pend_d   = esc_pend_q;
		bundle       = '0;

		priority if (action == qdt_pkg::ACT_END) begin
			bundle.mask = {1'b1, has_chars_q, 1'b0};
			bundle.done = 1'b1;
			in_quote_d   = 1'b0;
			open_quote_d = '0;
			has_chars_d  = 1'b0;
			esc_pend_d   = 1'b0;
		end else if (esc_pend_q) begin
			bundle.mask = 3'b001;
			bundle.ch0  = in_char;
			esc_pend_d  = 1'b0;
			has_chars_d = 1'b1;
		end else if (is_esc) begin
			esc_pend_d = 1'b1;
		end else begin
			if (is_quote) begin
				if (!in_quote_q) begin
					in_quote_d   = 1'b1;
					open_quote_d = in_char;
					add          = 1'b0;
				end else if (open_quote_q == in_char) begin
					// empty quoted span still yields a token holding a zero byte
					zero_emit    = !has_chars_q;
					has_chars_d  = 1'b1;
					in_quote_d   = 1'b0;
					open_quote_d = '0;
					add          = 1'b0;
				end
			end
			split    = !in_quote_d && is_split;
			kept     = !in_quote_d && is_kept;
			complete = (split || kept) && has_chars_d;
			if (split || kept)
				add = 1'b0;
			if (add)
				has_chars_d = 1'b1;
			if (complete)
				has_chars_d = 1'b0;
			bundle.mask = {kept, complete, add || zero_emit};
			bundle.ch0  = zero_emit ? 8'd0 : in_char;
			bundle.ch2  = in_char;
		end
	end

	assign bundle_valid = accept && (bundle.mask != 3'b000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q   <= 1'b0;
			open_quote_q <= '0;
			has_chars_q  <= 1'b0;
			esc_pend_q   <= 1'b0;
		end else if (accept) begin
			in_quote_q   <= in_quote_d;
			open_quote_q <= open_quote_d;
			has_chars_q  <= has_chars_d;
			esc_pend_q   <= esc_pend_d;
		end
	end

endmodule

FILE: design/qdt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdt_fifo
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module qdt_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  qdt_pkg::bundle_t  wdata,
	input  logic              rd,
	output qdt_pkg::bundle_t  rdata,
	output logic              full,
	output logic              empty
);

	qdt_pkg::bundle_t mem_q [qdt_pkg::QDEPTH];

	logic [qdt_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	logic [qdt_pkg::QCNT_W-1:0] cnt_q;
	logic                       do_wr, do_rd;

	assign full  = (cnt_q == qdt_pkg::QCNT_W'(qdt_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= wptr_q + qdt_pkg::QPTR_W'(1);
			if (do_rd)
				rptr_q <= rptr_q + qdt_pkg::QPTR_W'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + qdt_pkg::QCNT_W'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - qdt_pkg::QCNT_W'(1);
		end
	end

endmodule

FILE: design/qdt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdt_back
// Holds the current bundle and hands its results out one beat at a time.
// ----------------------------------------------------------------------------
module qdt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  qdt_pkg::bundle_t  q_data,
	output logic              q_rd,
	input  logic              pop,
	output logic              empty,
	output logic [1:0]        kind,
	output logic [7:0]        out_char,
	output logic              last
);

	logic [2:0] mask_q;
	logic [7:0] ch0_q, ch2_q;
	logic       done_q;

	logic [2:0] sel, rest;
	logic       take;

	assign empty = (mask_q == 3'b000);

	always_comb begin
		sel      = 3'b000;
		kind     = qdt_pkg::KIND_CHAR;
		out_char = 8'd0;
		priority if (mask_q[0]) begin
			sel      = 3'b001;
			kind     = qdt_pkg::KIND_CHAR;
			out_char = ch0_q;
		end else if (mask_q[1]) begin
			sel  = 3'b010;
			kind = qdt_pkg::KIND_TOKEN_END;
		end else if (mask_q[2]) begin
			sel = 3'b100;
			if (done_q) begin
				kind = qdt_pkg::KIND_DONE;
			end else begin
				kind     = qdt_pkg::KIND_DELIM;
				out_char = ch2_q;
			end
		end else begin
			sel = 3'b000;
		end
	end

	assign rest = mask_q & ~sel;
	assign last = !empty && (rest == 3'b000);
	// refill when idle or when the final beat of the bundle leaves
	assign take = empty || (pop && last);
	assign q_rd = take && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 3'b000;
		end else if (take) begin
			mask_q <= q_empty ? 3'b000 : q_data.mask;
		end else if (pop) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			ch0_q  <= q_data.ch0;
			ch2_q  <= q_data.ch2;
			done_q <= q_data.done;
		end
	end

endmodule

FILE: design/quoted_delimiter_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_delimiter_tokenizer
// Splits a byte stream into tokens with split/kept delimiters, quotes and
// escapes; emits token bytes, token ends, delimiter tokens and string done.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          action, in_char
//  result    pop / empty          kind, out_char, last
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One item is taken per cycle unless full; an item yields zero to three
//  results, one result beat per cycle while pop is high, so the result
//  side sets the pace. A four-entry bundle queue between classifier and
//  emitter absorbs stalls; full rises only when that queue is full.
//  Reset clears the control state and configuration; no warm-up after reset.
// ----------------------------------------------------------------------------
module quoted_delimiter_tokenizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            action,
	input  logic [7:0]                      in_char,
	output logic                            empty,
	input  logic                            pop,
	output logic [1:0]                      kind,
	output logic [7:0]                      out_char,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [qdt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qdt_pkg::SET_W-1:0]       cfg_data
);

	qdt_pkg::cfg_t    cfg_q;
	qdt_pkg::bundle_t f_bundle, q_data;
	logic             accept, f_valid, q_rd, q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				qdt_pkg::CFG_SPLIT_CHARS:  cfg_q.split_chars  <= cfg_data;
				qdt_pkg::CFG_SPLIT_COUNT:  cfg_q.split_count  <= cfg_data[qdt_pkg::CNT_W-1:0];
				qdt_pkg::CFG_KEPT_CHARS:   cfg_q.kept_chars   <= cfg_data;
				qdt_pkg::CFG_KEPT_COUNT:   cfg_q.kept_count   <= cfg_data[qdt_pkg::CNT_W-1:0];
				qdt_pkg::CFG_QUOTE_CHARS:  cfg_q.quote_chars  <= cfg_data;
				qdt_pkg::CFG_QUOTE_COUNT:  cfg_q.quote_count  <= cfg_data[qdt_pkg::CNT_W-1:0];
				qdt_pkg::CFG_ESCAPE_CHARS: cfg_q.escape_chars <= cfg_data;
				qdt_pkg::CFG_ESCAPE_COUNT: cfg_q.escape_count <= cfg_data[qdt_pkg::CNT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign accept = push && !full;

	qdt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (action),
		.in_char      (in_char),
		.cfg          (cfg_q),
		.bundle_valid (f_valid),
		.bundle       (f_bundle)
	);

	qdt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_valid),
		.wdata  (f_bundle),
		.rd     (q_rd),
		.rdata  (q_data),
		.full   (full),
		.empty  (q_empty)
	);

	qdt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_data),
		.q_rd     (q_rd),
		.pop      (pop),
		.empty    (empty),
		.kind     (kind),
		.out_char (out_char),
		.last     (last)
	);

endmodule

FILE: test/quoted_delimiter_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_delimiter_tokenizer_tb
// Self-checking bench: feeds strings of bytes and end-of-string items through
// the push/full side, predicts every token beat in the bench and checks each
// beat popped from the result side. Runs several delimiter, quote and escape
// settings with random idle and stall patterns on both sides.
// ----------------------------------------------------------------------------
module quoted_delimiter_tokenizer_tb;

	typedef struct packed {
		logic       act;
		logic [7:0] ch;
	} char_item_t;

	typedef struct {
		qdt_pkg::kind_t kind;
		logic [7:0]     ch;
		logic           last;
	} token_beat_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          push      = 1'b0;
	logic                          action    = qdt_pkg::ACT_CHAR;
	logic [7:0]                    in_char   = 8'h00;
	logic                          pop       = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic [qdt_pkg::CFG_IDX_W-1:0] cfg_index = qdt_pkg::CFG_SPLIT_CHARS;
	logic [qdt_pkg::SET_W-1:0]     cfg_data  = '0;
	logic                          full;
	logic                          empty;
	logic [1:0]                    kind;
	logic [7:0]                    out_char;
	logic                          last;
	logic                          cfg_ready;

	char_item_t  char_feed_q[$];
	token_beat_t token_beats_q[$];
	int          fail_count = 0;
	int          idle_pct   = 0;
	int          stall_pct  = 0;

	// bench copy of configuration and tokenizer state
	qdt_pkg::cfg_t cur_cfg         = '0;
	bit            in_quote        = 1'b0;
	logic [7:0]    open_quote      = 8'h00;
	bit            token_has_chars = 1'b0;
	bit            escape_pending  = 1'b0;

	logic [7:0] pool [8];
	logic [7:0] punct [7] = '{8'h20, 8'h2C, 8'h3B, 8'h7C, 8'h22, 8'h27, 8'h5C};
	int         send_idle [4] = '{0, 70, 0, 21};
	int         recv_stall [4] = '{0, 0, 70, 21};

	quoted_delimiter_tokenizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.in_char   (in_char),
		.empty     (empty),
		.pop       (pop),
		.kind      (kind),
		.out_char  (out_char),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// counts past eight still only look at the eight bytes of the set
	function automatic bit byte_in(logic [qdt_pkg::SET_W-1:0] bytes,
			logic [qdt_pkg::CNT_W-1:0] cnt, logic [7:0] c);
		for (int i = 0; i < qdt_pkg::SET_SIZE; i++) begin
			if (cnt > i && bytes[8*i +: 8] == c)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic add_beat(qdt_pkg::kind_t k, logic [7:0] c);
		token_beat_t b;
		b = '{k, c, 1'b0};
		token_beats_q = {token_beats_q, b};
	endtask

	task automatic tokenize_step(logic act, logic [7:0] c);
		int n0;
		bit add;
		bit complete;
		bit delim;
		n0 = token_beats_q.size();
		add = 1'b1;
		complete = 1'b0;
		delim = 1'b0;
		if (act == qdt_pkg::ACT_END) begin
			if (token_has_chars)
				add_beat(qdt_pkg::KIND_TOKEN_END, 8'h00);
			add_beat(qdt_pkg::KIND_DONE, 8'h00);
			in_quote = 1'b0;
			open_quote = 8'h00;
			token_has_chars = 1'b0;
			escape_pending = 1'b0;
		end else if (escape_pending) begin
			escape_pending = 1'b0;
			add_beat(qdt_pkg::KIND_CHAR, c);
			token_has_chars = 1'b1;
		end else if (byte_in(cur_cfg.escape_chars, cur_cfg.escape_count, c)) begin
			escape_pending = 1'b1;
		end else begin
			if (byte_in(cur_cfg.quote_chars, cur_cfg.quote_count, c)) begin
				if (!in_quote) begin
					in_quote = 1'b1;
					open_quote = c;
					add = 1'b0;
				end else if (open_quote == c) begin
					// empty quoted span still yields a token: a zero byte
					if (!token_has_chars) begin
						add_beat(qdt_pkg::KIND_CHAR, 8'h00);
						token_has_chars = 1'b1;
					end
					in_quote = 1'b0;
					open_quote = 8'h00;
					add = 1'b0;
				end
			end
			if (!in_quote && byte_in(cur_cfg.split_chars, cur_cfg.split_count, c)) begin
				complete = token_has_chars;
				add = 1'b0;
			end
			if (!in_quote && byte_in(cur_cfg.kept_chars, cur_cfg.kept_count, c)) begin
				complete = complete | token_has_chars;
				add = 1'b0;
				delim = 1'b1;
			end
			if (add) begin
				add_beat(qdt_pkg::KIND_CHAR, c);
				token_has_chars = 1'b1;
			end
			if (complete && token_has_chars) begin
				add_beat(qdt_pkg::KIND_TOKEN_END, 8'h00);
				token_has_chars = 1'b0;
			end
			if (delim)
				add_beat(qdt_pkg::KIND_DELIM, c);
		end
		if (token_beats_q.size() > n0)
			token_beats_q[token_beats_q.size()-1].last = 1'b1;
	endtask

	task automatic check_beat();
		token_beat_t exp;
		if (token_beats_q.size() == 0) begin
			$error("unexpected beat: kind %0d out_char %0h last %0b", kind, out_char, last);
			fail_count++;
		end else begin
			exp = token_beats_q.pop_front();
			if (kind !== exp.kind) begin
				$error("kind: expected %0d, got %0d", exp.kind, kind);
				fail_count++;
			end
			if (out_char !== exp.ch) begin
				$error("out_char: expected %0h, got %0h", exp.ch, out_char);
				fail_count++;
			end
			if (last !== exp.last) begin
				$error("last: expected %0b, got %0b", exp.last, last);
				fail_count++;
			end
		end
	endtask

	// driver: one beat per cycle from the feed queue unless full, idling at random
	always @(posedge clk) begin
		if (push && !full)
			void'(char_feed_q.pop_front());
		if (char_feed_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
			push <= 1'b1;
			action <= char_feed_q[0].act;
			in_char <= char_feed_q[0].ch;
		end else begin
			push <= 1'b0;
		end
	end

	// monitor: predict on accepted input, check on accepted result
	always @(posedge clk) begin
		if (push && !full)
			tokenize_step(action, in_char);
		if (pop && !empty)
			check_beat();
		pop <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic write_reg(logic [qdt_pkg::CFG_IDX_W-1:0] idx,
			logic [qdt_pkg::SET_W-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			qdt_pkg::CFG_SPLIT_CHARS:  cur_cfg.split_chars = d;
			qdt_pkg::CFG_SPLIT_COUNT:  cur_cfg.split_count = d[qdt_pkg::CNT_W-1:0];
			qdt_pkg::CFG_KEPT_CHARS:   cur_cfg.kept_chars = d;
			qdt_pkg::CFG_KEPT_COUNT:   cur_cfg.kept_count = d[qdt_pkg::CNT_W-1:0];
			qdt_pkg::CFG_QUOTE_CHARS:  cur_cfg.quote_chars = d;
			qdt_pkg::CFG_QUOTE_COUNT:  cur_cfg.quote_count = d[qdt_pkg::CNT_W-1:0];
			qdt_pkg::CFG_ESCAPE_CHARS: cur_cfg.escape_chars = d;
			qdt_pkg::CFG_ESCAPE_COUNT: cur_cfg.escape_count = d[qdt_pkg::CNT_W-1:0];
			default: ;
		endcase
	endtask

	// count registers only use the low nibble; junk above it
	function automatic logic [qdt_pkg::SET_W-1:0] count_word(logic [qdt_pkg::CNT_W-1:0] c);
		logic [qdt_pkg::SET_W-1:0] w;
		w = {$urandom, $urandom};
		w[qdt_pkg::CNT_W-1:0] = c;
		return w;
	endfunction

	task automatic write_all(logic [qdt_pkg::SET_W-1:0] s, logic [qdt_pkg::SET_W-1:0] k,
			logic [qdt_pkg::SET_W-1:0] q, logic [qdt_pkg::SET_W-1:0] e,
			logic [qdt_pkg::CNT_W-1:0] sc, logic [qdt_pkg::CNT_W-1:0] kc,
			logic [qdt_pkg::CNT_W-1:0] qc, logic [qdt_pkg::CNT_W-1:0] ec);
		write_reg(qdt_pkg::CFG_SPLIT_CHARS, s);
		write_reg(qdt_pkg::CFG_SPLIT_COUNT, count_word(sc));
		write_reg(qdt_pkg::CFG_KEPT_CHARS, k);
		write_reg(qdt_pkg::CFG_KEPT_COUNT, count_word(kc));
		write_reg(qdt_pkg::CFG_QUOTE_CHARS, q);
		write_reg(qdt_pkg::CFG_QUOTE_COUNT, count_word(qc));
		write_reg(qdt_pkg::CFG_ESCAPE_CHARS, e);
		write_reg(qdt_pkg::CFG_ESCAPE_COUNT, count_word(ec));
	endtask

	task automatic fill_pool();
		for (int i = 0; i < 8; i++)
			pool[i] = (i < 4) ? punct[$urandom_range(0, 6)] : 8'($urandom_range(0, 255));
	endtask

	function automatic logic [qdt_pkg::CNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 9)
			return qdt_pkg::CNT_W'($urandom_range(9, 15));
		return qdt_pkg::CNT_W'($urandom_range(1, 8));
	endfunction

	// sets drawn from one small pool so they overlap often
	task automatic set_random_cfg();
		logic [qdt_pkg::SET_W-1:0] sets [4];
		fill_pool();
		for (int j = 0; j < 4; j++)
			for (int i = 0; i < qdt_pkg::SET_SIZE; i++)
				sets[j][8*i +: 8] = pool[$urandom_range(0, 7)];
		write_all(sets[0], sets[1], sets[2], sets[3],
			pick_count(), pick_count(), pick_count(), pick_count());
	endtask

	task automatic feed_char(logic [7:0] c);
		char_item_t it;
		it = '{qdt_pkg::ACT_CHAR, c};
		char_feed_q = {char_feed_q, it};
	endtask

	task automatic feed_end();
		char_item_t it;
		it = '{qdt_pkg::ACT_END, 8'h00};
		char_feed_q = {char_feed_q, it};
	endtask

	// mostly set bytes and letters; some raw bytes as noise
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return pool[$urandom_range(0, 7)];
		if (r < 85)
			return 8'h61 + 8'($urandom_range(0, 25));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic feed_strings(int n_items);
		int cnt;
		int len;
		cnt = 0;
		while (cnt < n_items) begin
			len = $urandom_range(0, 10);
			for (int i = 0; i < len; i++)
				feed_char(pick_byte());
			feed_end();
			cnt += len + 1;
		end
	endtask

	// block drained: feed empty, nothing owed, then a settling wait for items
	// that produce no beat
	task automatic wait_idle();
		do @(posedge clk);
		while (char_feed_q.size() != 0 || push || token_beats_q.size() != 0 || !empty);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [7:0] directed [18];
		directed = '{8'h61, 8'h5C, 8'h22, 8'h20, 8'h22, 8'h22, 8'h22, 8'h27, 8'h5C,
			8'h22, 8'h22, 8'h7C, 8'h27, 8'h7A, 8'h27, 8'hFF, 8'h00, 8'h5C};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// split " , | '", kept "; |", quotes " and ', escape backslash
		write_all(64'h0000_0000_277C_2C20, 64'h7C3B, 64'h2722, 64'h5C,
			4'd4, 4'd2, 4'd2, 4'd1);
		// escaped quote, empty span, other quote in span, escape in span,
		// byte in both delimiter sets, closing quote that also splits,
		// byte extremes, escape pending at end, quote open at end, empty string
		foreach (directed[i])
			feed_char(directed[i]);
		feed_end();
		feed_char(8'h22);
		feed_char(8'h71);
		feed_end();
		feed_end();

		for (int ph = 1; ph <= 8; ph++) begin
			wait_idle();
			case (ph)
				1: begin
					fill_pool();
					write_all('0, '0, '0, '0, '0, '0, '0, '0);
				end
				4: begin
					// every set all 0xFF, counts past eight
					fill_pool();
					pool[0] = 8'hFF;
					pool[1] = 8'hFF;
					write_all('1, '1, '1, '1, '1, '1, '1, '1);
				end
				default: set_random_cfg();
			endcase
			idle_pct = send_idle[ph % 4];
			stall_pct = recv_stall[ph % 4];
			feed_strings(34);
		end
		wait_idle();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
